// ----- hw/rtl/spd_pkg.sv -----
// Shared types and constants for the serial packet deframer.
// No dependencies; imported by spd_hunt, serial_packet_deframer and tb.
`timescale 1ns / 1ps

package spd_pkg;

  localparam int WIN_LEN   = 6;
  localparam int FILL_W    = 3;
  localparam int IDLE_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 16;
  localparam int LEFT_W    = 17;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  localparam logic [LEN_W-1:0]  MAX_FIELD_LEN_RST = 16'd255;
  localparam logic [LEN_W-1:0]  GAP_LIMIT_RST     = 16'd100;
  localparam logic [IDLE_W-1:0] IDLE_MAX          = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELD_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT     = 2'd1;

  // input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ABORT  = 2'd2;

  typedef logic [WIN_LEN-1:0][7:0] win_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [LEN_W-1:0] data_len;
    logic [7:0]       option_len;
    logic [7:0]       packet_type;
    logic [7:0]       header_check;
    logic [7:0]       body_byte;
    logic             last;
  } out_item_t;

  // header hunt result handed to the top level
  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] data_len;
    logic [7:0]       option_len;
    logic [7:0]       packet_type;
    logic [7:0]       header_check;
  } hdr_t;

endpackage

// ----- hw/rtl/spd_hunt.sv -----
// Header hunt: appends one byte to the sync window, checks lengths on a full
// window and realigns to the next sync byte on a rejected header. Uses spd_pkg.
`timescale 1ns / 1ps

module spd_hunt import spd_pkg::*; (
  input  win_t              win,
  input  logic [FILL_W-1:0] fill,
  input  logic [7:0]        rx_byte,
  input  logic [LEN_W-1:0]  max_len,
  output win_t              win_next,
  output logic [FILL_W-1:0] fill_next,
  output hdr_t              hdr
);

  win_t              w;
  logic [FILL_W-1:0] fi;
  logic [FILL_W-1:0] fa;
  logic [FILL_W-1:0] shift;
  logic [LEN_W-1:0]  dl;
  logic [7:0]        ol;

  always_comb begin
    w         = win;
    fi        = '0;
    fa        = '0;
    shift     = '0;
    dl        = '0;
    ol        = '0;
    win_next  = win;
    fill_next = fill;
    hdr       = '0;
    // with an empty window only a sync byte starts a hunt
    if (!(fill == '0 && rx_byte != SYNC_BYTE)) begin
      fi    = (fill >= FILL_W'(WIN_LEN)) ? '0 : fill;
      w[fi] = rx_byte;
      fa    = fi + FILL_W'(1);
      if (fa < FILL_W'(WIN_LEN)) begin
        win_next  = w;
        fill_next = fa;
      end else begin
        dl = {w[1], w[2]};
        ol = w[3];
        if (dl > max_len || {8'h00, ol} > max_len) begin
          // drop the sync byte, realign on the next sync in the window
          for (int i = WIN_LEN - 1; i >= 1; i--) begin
            if (w[i] == SYNC_BYTE) begin
              shift = FILL_W'(i);
            end
          end
          if (shift == '0) begin
            win_next  = w;
            fill_next = '0;
          end else begin
            win_next  = win_t'(w >> {shift, 3'b000});
            fill_next = FILL_W'(WIN_LEN) - shift;
          end
        end else begin
          win_next         = w;
          fill_next        = '0;
          hdr.found        = 1'b1;
          hdr.data_len     = dl;
          hdr.option_len   = ol;
          hdr.packet_type  = w[4];
          hdr.header_check = w[5];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/serial_packet_deframer.sv -----
// Serial packet deframer top level: input register, one pass of framing
// logic, result register. Uses spd_pkg and spd_hunt.
`timescale 1ns / 1ps

// Takes one item (a received byte or a time tick) per clock and turns the byte
// stream into header, body and abort results. An item is held in an input
// register and then processed through a single pass of the header window
// logic into the result register; the sustained rate is one item per cycle
// while the result register is free or its result is being taken.
// The input register refills in the same cycle it drains; the block stops taking
// items only while the input register is full and the result register holds a
// result nobody is taking. The configuration port is always ready and must be
// written only while idle.

module serial_packet_deframer import spd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  // configuration
  logic [LEN_W-1:0] max_field_len;
  logic [LEN_W-1:0] gap_limit_ticks;

  // input register
  logic     in_q_valid;
  in_item_t in_q;

  // framing state
  win_t              hunt_window, hunt_window_next;
  logic [FILL_W-1:0] window_fill, window_fill_next;
  logic              in_packet, in_packet_next;
  logic [LEFT_W-1:0] bytes_left, bytes_left_next;
  logic [IDLE_W-1:0] idle_ticks, idle_ticks_next;

  // hunt unit
  win_t              hunt_win_out;
  logic [FILL_W-1:0] hunt_fill_in, hunt_fill_out;
  hdr_t              hdr;

  logic              go;
  logic              emit;
  out_item_t         res;
  logic              stale;
  logic [IDLE_W-1:0] idle_inc;

  assign cfg_ready = 1'b1;
  assign go        = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || go;

  assign stale        = idle_ticks > {1'b0, gap_limit_ticks};
  assign idle_inc     = (idle_ticks == IDLE_MAX) ? idle_ticks : idle_ticks + IDLE_W'(1);
  assign hunt_fill_in = stale ? '0 : window_fill;

  spd_hunt u_hunt (
    .win       (hunt_window),
    .fill      (hunt_fill_in),
    .rx_byte   (in_q.rx_byte),
    .max_len   (max_field_len),
    .win_next  (hunt_win_out),
    .fill_next (hunt_fill_out),
    .hdr       (hdr)
  );

  always_comb begin
    hunt_window_next = hunt_window;
    window_fill_next = window_fill;
    in_packet_next   = in_packet;
    bytes_left_next  = bytes_left;
    idle_ticks_next  = idle_ticks;
    emit             = 1'b0;
    res              = '0;
    if (in_q.command == CMD_TICK) begin
      idle_ticks_next = idle_inc;
      if (idle_inc > {1'b0, gap_limit_ticks}) begin
        window_fill_next = '0;
        if (in_packet) begin
          in_packet_next  = 1'b0;
          bytes_left_next = '0;
          emit            = 1'b1;
          res.kind        = KIND_ABORT;
        end
      end
    end else begin
      idle_ticks_next = '0;
      if (stale && in_packet) begin
        // abort the open packet; the byte then starts a fresh hunt
        in_packet_next   = 1'b0;
        bytes_left_next  = '0;
        hunt_window_next = hunt_win_out;
        window_fill_next = hunt_fill_out;
        emit             = 1'b1;
        res.kind         = KIND_ABORT;
      end else if (in_packet && !stale) begin
        emit          = 1'b1;
        res.kind      = KIND_BODY;
        res.body_byte = in_q.rx_byte;
        res.last      = bytes_left <= LEFT_W'(1);
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - LEFT_W'(1);
        end
        in_packet_next = bytes_left > LEFT_W'(1);
      end else begin
        hunt_window_next = hunt_win_out;
        window_fill_next = hunt_fill_out;
        if (hdr.found) begin
          emit             = 1'b1;
          res.kind         = KIND_HEADER;
          res.data_len     = hdr.data_len;
          res.option_len   = hdr.option_len;
          res.packet_type  = hdr.packet_type;
          res.header_check = hdr.header_check;
          in_packet_next   = 1'b1;
          bytes_left_next  = LEFT_W'(hdr.data_len) + LEFT_W'(hdr.option_len) + LEFT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_field_len   <= MAX_FIELD_LEN_RST;
      gap_limit_ticks <= GAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_FIELD_LEN: max_field_len   <= cfg_data;
        REG_GAP_LIMIT:     gap_limit_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
      in_packet   <= 1'b0;
      bytes_left  <= '0;
      idle_ticks  <= IDLE_MAX;
    end else if (go) begin
      window_fill <= window_fill_next;
      in_packet   <= in_packet_next;
      bytes_left  <= bytes_left_next;
      idle_ticks  <= idle_ticks_next;
    end
    if (go) begin
      hunt_window <= hunt_window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (go && emit) begin
      out_data <= res;
    end
  end

  // an open packet always has bytes due and an empty hunt window
  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    in_packet |-> bytes_left != '0)
    else $error("open packet with no bytes left");

  a_open_window_empty: assert property (@(posedge clk) disable iff (rst)
    in_packet |-> window_fill == '0)
    else $error("hunt window not empty inside a packet");

  a_fill_below_full: assert property (@(posedge clk) disable iff (rst)
    window_fill < FILL_W'(WIN_LEN))
    else $error("hunt window left full");

  a_header_opens: assert property (@(posedge clk) disable iff (rst)
    go && emit && res.kind == KIND_HEADER |=> in_packet)
    else $error("header transfer did not open a packet");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    go && emit && res.kind == KIND_BODY && res.last |=> !in_packet)
    else $error("packet still open after last byte");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for serial_packet_deframer: directed and random byte/tick streams,
// checked against an in-bench model of the header hunt and packet body logic.
// Depends on spd_pkg and the serial_packet_deframer RTL.
`timescale 1ns / 1ps

module tb;
  import spd_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 330;

  // indexes past the register file; writes there must not change anything
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

  // random phases: {phase4, ..., phase0}
  localparam logic [4:0][LEN_W-1:0] PHASE_MAX_LEN = {16'hFFFF, 16'd0, 16'd40, 16'd6, 16'd255};
  localparam logic [4:0][LEN_W-1:0] PHASE_GAP     = {16'd8, 16'd2, 16'd20, 16'd3, 16'd100};

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0] cfg_data;

  out_item_t due_results[$];
  int errors = 0;
  int items_sent = 0;
  int stall_cnt = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  // model state
  logic [7:0] win_buf [WIN_LEN];
  int win_fill;
  bit pkt_open;
  logic [LEFT_W-1:0] pkt_left;
  logic [IDLE_W-1:0] idle_cnt;
  logic [LEN_W-1:0] lim_len;
  logic [LEN_W-1:0] lim_gap;

  serial_packet_deframer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void model_reset();
    int j;
    for (j = 0; j < WIN_LEN; j++) win_buf[j] = 8'h00;
    win_fill = 0;
    pkt_open = 1'b0;
    pkt_left = '0;
    idle_cnt = IDLE_MAX;
    lim_len  = MAX_FIELD_LEN_RST;
    lim_gap  = GAP_LIMIT_RST;
  endfunction

  // feeds one byte to the header window; returns 1 with r filled on a header
  function automatic bit hunt_feed(input logic [7:0] b, output out_item_t r);
    logic [LEFT_W-1:0] dl;
    logic [LEFT_W-1:0] ol;
    int k;
    int j;
    r = '0;
    if (win_fill == 0 && b != SYNC_BYTE) return 1'b0;
    if (win_fill >= WIN_LEN) win_fill = 0;
    win_buf[win_fill] = b;
    win_fill++;
    if (win_fill < WIN_LEN) return 1'b0;
    dl = {1'b0, win_buf[1], win_buf[2]};
    ol = {9'd0, win_buf[3]};
    if (dl > lim_len || ol > lim_len) begin
      // drop the sync byte and slide to the next sync in the window
      k = 1;
      while (k < win_fill && win_buf[k] != SYNC_BYTE) k++;
      if (k >= win_fill) begin
        win_fill = 0;
      end else begin
        for (j = 0; j < win_fill - k; j++) win_buf[j] = win_buf[j + k];
        win_fill -= k;
      end
      return 1'b0;
    end
    r.kind         = KIND_HEADER;
    r.data_len     = dl[LEN_W-1:0];
    r.option_len   = win_buf[3];
    r.packet_type  = win_buf[4];
    r.header_check = win_buf[5];
    pkt_open = 1'b1;
    pkt_left = dl + ol + LEFT_W'(1);
    win_fill = 0;
    return 1'b1;
  endfunction

  function automatic bit deframe_step(input in_item_t it, output out_item_t r);
    out_item_t unused;
    bit stale;
    r = '0;
    if (it.command == CMD_TICK) begin
      if (idle_cnt < IDLE_MAX) idle_cnt++;
      if (idle_cnt > lim_gap) begin
        win_fill = 0;
        if (pkt_open) begin
          pkt_open = 1'b0;
          pkt_left = '0;
          r.kind = KIND_ABORT;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    stale = idle_cnt > lim_gap;
    idle_cnt = '0;
    if (stale) begin
      win_fill = 0;
      if (pkt_open) begin
        pkt_open = 1'b0;
        pkt_left = '0;
        r.kind = KIND_ABORT;
        void'(hunt_feed(it.rx_byte, unused));
        return 1'b1;
      end
    end
    if (pkt_open) begin
      r.kind = KIND_BODY;
      r.body_byte = it.rx_byte;
      r.last = (pkt_left <= 1);
      if (pkt_left > 0) pkt_left--;
      if (pkt_left == 0) pkt_open = 1'b0;
      return 1'b1;
    end
    return hunt_feed(it.rx_byte, r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_item(input logic cmd, input logic [7:0] b);
    in_item_t it;
    out_item_t res;
    int gap;
    it.command = cmd;
    it.rx_byte = b;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (deframe_step(it, res)) due_results.push_back(res);
    items_sent++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_header(input logic [LEN_W-1:0] dl, input logic [7:0] ol,
                             input logic [7:0] ptype, input logic [7:0] hchk);
    push_item(CMD_BYTE, SYNC_BYTE);
    push_item(CMD_BYTE, dl[15:8]);
    push_item(CMD_BYTE, dl[7:0]);
    push_item(CMD_BYTE, ol);
    push_item(CMD_BYTE, ptype);
    push_item(CMD_BYTE, hchk);
  endtask

  // stop offering items, let every due result arrive, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAX_FIELD_LEN) lim_len = val;
    else if (idx == REG_GAP_LIMIT) lim_gap = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // noise drop, rejected header with rescan, zero-length packet
  task automatic test_hunt();
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    push_header(16'h0100, SYNC_BYTE, 8'h00, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h01);
    push_item(CMD_BYTE, 8'h02);
    push_item(CMD_BYTE, 8'hAB);
  endtask

  task automatic test_tick_abort();
    write_reg(REG_GAP_LIMIT, 16'd2);
    push_header(16'd1, 8'd0, 8'h7E, 8'h81);
    push_item(CMD_BYTE, 8'h00);
    push_ticks(3);
  endtask

  // byte arriving after the limit was lowered below the tick count
  task automatic test_stale_byte();
    write_reg(REG_GAP_LIMIT, 16'hFFFF);
    push_header(16'd0, 8'd0, 8'h00, 8'h00);
    push_ticks(2);
    write_reg(REG_GAP_LIMIT, 16'd0);
    push_header(16'd0, 8'd0, 8'hC3, 8'h3C);
    push_ticks(1);
    write_reg(REG_SPARE, LEN_W'($urandom_range(0, 65535)));
    write_reg(REG_RESERVED, LEN_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_length_limits();
    write_reg(REG_MAX_FIELD_LEN, 16'd0);
    push_header(16'd0, 8'd1, SYNC_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h5A);
    push_item(CMD_BYTE, 8'hA5);
    push_item(CMD_BYTE, 8'hFF);
    write_reg(REG_MAX_FIELD_LEN, 16'hFFFF);
    push_header(16'hFFFF, 8'hFF, 8'h01, 8'h02);
    push_item(CMD_BYTE, 8'h12);
    push_item(CMD_BYTE, 8'h34);
    push_ticks(1);
  endtask

  // receiver holds off while a long packet keeps coming
  task automatic test_backpressure();
    write_reg(REG_MAX_FIELD_LEN, MAX_FIELD_LEN_RST);
    write_reg(REG_GAP_LIMIT, GAP_LIMIT_RST);
    hold_req = 1'b1;
    no_idle = 1'b1;
    push_header(16'd40, 8'd0, 8'h66, 8'h99);
    repeat (41) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int phase;
    int r;
    int full;
    int n;
    int goal;
    logic [LEN_W-1:0] dl;
    logic [7:0] ol;
    for (phase = 0; phase < 5; phase++) begin
      write_reg(REG_MAX_FIELD_LEN, PHASE_MAX_LEN[phase]);
      write_reg(REG_GAP_LIMIT, PHASE_GAP[phase]);
      no_idle = (phase == 2);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          dl = LEN_W'($urandom_range(0, 8));
          ol = 8'($urandom_range(0, 4));
          if ($urandom_range(0, 7) == 0) begin
            dl = LEN_W'($urandom_range(0, 65535));
            ol = 8'($urandom_range(0, 255));
          end
          push_header(dl, ol, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          full = int'(dl) + int'(ol) + 1;
          // long or cut-short bodies leave the packet open for what follows
          if (full > 24 || $urandom_range(0, 9) == 0)
            n = $urandom_range(0, (full > 24) ? 24 : full);
          else
            n = full;
          repeat (n) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        end else if (r < 85) begin
          repeat ($urandom_range(1, 4)) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        end else begin
          n = ($urandom_range(0, 4) == 0) ? int'(PHASE_GAP[phase]) + 1
                                          : int'($urandom_range(1, 2));
          push_ticks((n > 40) ? 40 : n);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic check_result(input out_item_t want, input out_item_t got);
    if (got.kind !== want.kind) begin
      errors++;
      $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
    end
    if (got.data_len !== want.data_len) begin
      errors++;
      $display("%0t: data_len expected %0d, got %0d", $time, want.data_len, got.data_len);
    end
    if (got.option_len !== want.option_len) begin
      errors++;
      $display("%0t: option_len expected %0d, got %0d", $time, want.option_len,
               got.option_len);
    end
    if (got.packet_type !== want.packet_type) begin
      errors++;
      $display("%0t: packet_type expected %h, got %h", $time, want.packet_type,
               got.packet_type);
    end
    if (got.header_check !== want.header_check) begin
      errors++;
      $display("%0t: header_check expected %h, got %h", $time, want.header_check,
               got.header_check);
    end
    if (got.body_byte !== want.body_byte) begin
      errors++;
      $display("%0t: body_byte expected %h, got %h", $time, want.body_byte, got.body_byte);
    end
    if (got.last !== want.last) begin
      errors++;
      $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due, got %p", $time, out_data);
      end else begin
        check_result(due_results.pop_front(), out_data);
      end
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (1 + pick_gap()) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_hunt();
    test_tick_abort();
    test_stale_byte();
    test_length_limits();
    test_backpressure();
    test_random();
    drain();

    if (errors == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
